@@ rtl/tvbf_pkg.sv @@
// Shared constants and the command type for the text view byte filter.
// No dependencies; every other file of the block imports this package.
package tvbf_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int NUM_W         = 4 * NUMBER_DIGITS;
    localparam int DIG_IDX_W     = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
    // Steps: digits, then the tab, then the optional lead byte, then the main byte.
    localparam int STEP_TAB      = NUMBER_DIGITS;
    localparam int STEP_PRE      = NUMBER_DIGITS + 1;
    localparam int STEP_MAIN     = NUMBER_DIGITS + 2;
    localparam int STEP_W        = $clog2(NUMBER_DIGITS + 3);

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUMBER_ALL,
        REG_NUMBER_NONBLANK,
        REG_SQUEEZE_BLANK,
        REG_SHOW_ENDS,
        REG_SHOW_TABS,
        REG_SHOW_NONPRINTING,
        REG_SPARE_6,
        REG_SPARE_7
    } t_cfg_reg;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_I         = 8'h49;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT   = 8'd32;
    localparam logic [7:0] CARET_OFFSET = 8'd64;

    typedef struct packed {
        logic                     has_num;
        logic [NUM_W-1:0]         num_bcd;
        logic [NUMBER_DIGITS-1:0] blank;
        logic                     has_pre;
        logic [7:0]               pre_byte;
        logic [7:0]               main_byte;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

@@ rtl/text_view_byte_filter_unit.sv @@
// Text view byte filter: turns a raw text byte stream into its viewed form,
// with optional line numbers, squeezed blank lines, '$' at line ends, ^I tabs
// and caret notation for control bytes. An input byte is taken in any cycle
// in which the command queue has room, and results leave at one byte per
// cycle while pop is held. A squeezed newline yields no result; any other
// byte yields one to nine result bytes (a numbered line start yields eight,
// or nine when a lead byte such as '$' or '^' is added), so the sustained
// input rate is set by the output expander, e.g. one byte per cycle for plain
// text. An item's first result is held in the command queue, then in the
// output register. The four-entry queue lets input continue while a number
// prefix is expanded. Depends on tvbf_pkg, tvbf_front, tvbf_queue, tvbf_back.
module text_view_byte_filter_unit
    import tvbf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_in_byte,
    input  logic                 pop,
    output logic                 empty,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_of_run
);

    t_cmd          cmd, head;
    logic          cmd_push, head_pop;
    t_queue_status q_status;

    assign o_cfg_ready = 1'b1;
    assign full        = q_status.full;

    tvbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (push && !q_status.full),
        .i_in_byte   (i_in_byte),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd)
    );

    tvbf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (cmd_push),
        .i_cmd    (cmd),
        .i_pop    (head_pop),
        .o_head   (head),
        .o_status (q_status)
    );

    tvbf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_head_empty  (q_status.empty),
        .o_head_pop    (head_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

@@ rtl/tvbf_front.sv @@
// Front end: configuration registers, line state and classification of each
// accepted item into an expansion command. Depends on tvbf_pkg.
module tvbf_front
    import tvbf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_accept,
    input  logic [7:0]           i_in_byte,
    output logic                 o_cmd_push,
    output t_cmd                 o_cmd
);

    logic             r_number_all, r_number_nonblank, r_squeeze_blank;
    logic             r_show_ends, r_show_tabs, r_show_nonprint;
    logic             r_at_line_start;
    logic [1:0]       r_blank_run;
    logic [NUM_W-1:0] r_line_bcd;

    logic             n_at_line_start;
    logic [1:0]       n_blank_run;
    logic [NUM_W-1:0] n_line_bcd;

    logic             is_nl;
    logic             empty_line;
    logic [1:0]       blank_inc;
    logic             drop;
    logic             do_number;
    logic             all_nines;
    logic             carry;
    logic             leading;
    logic [3:0]       digit;
    logic [NUM_W-1:0] bumped;
    logic [NUMBER_DIGITS-1:0] blank_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_all      <= 1'b0;
            r_number_nonblank <= 1'b0;
            r_squeeze_blank   <= 1'b0;
            r_show_ends       <= 1'b0;
            r_show_tabs       <= 1'b0;
            r_show_nonprint   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NUMBER_ALL:       r_number_all      <= i_cfg_data;
                REG_NUMBER_NONBLANK:  r_number_nonblank <= i_cfg_data;
                REG_SQUEEZE_BLANK:    r_squeeze_blank   <= i_cfg_data;
                REG_SHOW_ENDS:        r_show_ends       <= i_cfg_data;
                REG_SHOW_TABS:        r_show_tabs       <= i_cfg_data;
                REG_SHOW_NONPRINTING: r_show_nonprint   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturating BCD increment and the leading-blank mask of the current number.
    always_comb begin
        all_nines  = 1'b1;
        carry      = 1'b1;
        leading    = 1'b1;
        bumped     = r_line_bcd;
        blank_mask = '0;
        for (int d = 0; d < NUMBER_DIGITS; d++) begin
            digit = r_line_bcd[4*d +: 4];
            if (digit != 4'd9) all_nines = 1'b0;
            if (carry) begin
                if (digit == 4'd9) begin
                    bumped[4*d +: 4] = 4'd0;
                end else begin
                    bumped[4*d +: 4] = digit + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        for (int d = NUMBER_DIGITS - 1; d >= 0; d--) begin
            digit = r_line_bcd[4*d +: 4];
            if (digit != 4'd0 || d == 0) leading = 1'b0;
            blank_mask[d] = leading;
        end
    end

    always_comb begin
        is_nl      = (i_in_byte == CH_LF);
        empty_line = is_nl && r_at_line_start;
        blank_inc  = (r_blank_run == 2'd3) ? 2'd3 : r_blank_run + 2'd1;
        drop       = empty_line && r_squeeze_blank && (blank_inc > 2'd1);
        do_number  = r_at_line_start &&
                     ((r_number_nonblank && !is_nl) ||
                      (r_number_all && !r_number_nonblank));

        n_blank_run     = empty_line ? blank_inc : (is_nl ? r_blank_run : 2'd0);
        n_at_line_start = drop ? r_at_line_start : is_nl;
        n_line_bcd      = (!drop && do_number && !all_nines) ? bumped : r_line_bcd;

        o_cmd.has_num   = do_number;
        o_cmd.num_bcd   = r_line_bcd;
        o_cmd.blank     = blank_mask;
        o_cmd.has_pre   = 1'b0;
        o_cmd.pre_byte  = CH_CARET;
        o_cmd.main_byte = i_in_byte;
        if (is_nl) begin
            o_cmd.has_pre  = r_show_ends;
            o_cmd.pre_byte = CH_DOLLAR;
        end else if (i_in_byte == CH_TAB) begin
            if (r_show_tabs) begin
                o_cmd.has_pre   = 1'b1;
                o_cmd.main_byte = CH_I;
            end
        end else if (r_show_nonprint && i_in_byte < CTRL_LIMIT) begin
            o_cmd.has_pre   = 1'b1;
            o_cmd.main_byte = i_in_byte + CARET_OFFSET;
        end else if (r_show_nonprint && i_in_byte == CH_DEL) begin
            o_cmd.has_pre   = 1'b1;
            o_cmd.main_byte = i_in_byte - CARET_OFFSET;
        end

        o_cmd_push = i_accept && !drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_blank_run     <= 2'd0;
            r_line_bcd      <= NUM_W'(1);
        end else if (i_accept) begin
            r_at_line_start <= n_at_line_start;
            r_blank_run     <= n_blank_run;
            r_line_bcd      <= n_line_bcd;
        end
    end

endmodule

@@ rtl/tvbf_queue.sv @@
// Short command queue between the front end and the expander.
// Depends on tvbf_pkg for the command type and depth.
module tvbf_queue
    import tvbf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_cmd,
    input  logic          i_pop,
    output t_cmd          o_head,
    output t_queue_status o_status
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W:0]   r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   count;

    assign count           = r_wr_ptr - r_rd_ptr;
    assign o_status.full   = count[QPTR_W];
    assign o_status.empty  = (r_wr_ptr == r_rd_ptr);
    assign o_head          = r_mem[r_rd_ptr[QPTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_status.full) begin
            r_mem[r_wr_ptr[QPTR_W-1:0]] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_status.full) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop && !o_status.empty) r_rd_ptr <= r_rd_ptr + 1'b1;
        end
    end

endmodule

@@ rtl/tvbf_back.sv @@
// Expander: walks each queued command byte by byte into a registered output.
// Depends on tvbf_pkg.
module tvbf_back
    import tvbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_head_empty,
    output logic       o_head_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;

    logic              load;
    logic [STEP_W-1:0] start_step, cur_step, n_step;
    logic [DIG_IDX_W-1:0] dig_idx;
    logic [7:0]        byte_sel;
    logic              is_last;

    always_comb begin
        if (i_head.has_num)      start_step = '0;
        else if (i_head.has_pre) start_step = STEP_W'(STEP_PRE);
        else                     start_step = STEP_W'(STEP_MAIN);
        cur_step = r_busy ? r_step : start_step;
        is_last  = (cur_step == STEP_W'(STEP_MAIN));
        n_step   = (cur_step == STEP_W'(STEP_TAB) && !i_head.has_pre) ?
                   STEP_W'(STEP_MAIN) : cur_step + 1'b1;

        dig_idx  = DIG_IDX_W'(NUMBER_DIGITS - 1) - cur_step[DIG_IDX_W-1:0];
        if (cur_step == STEP_W'(STEP_MAIN))      byte_sel = i_head.main_byte;
        else if (cur_step == STEP_W'(STEP_PRE))  byte_sel = i_head.pre_byte;
        else if (cur_step == STEP_W'(STEP_TAB))  byte_sel = CH_TAB;
        else if (i_head.blank[dig_idx])          byte_sel = CH_SPACE;
        else byte_sel = CH_ZERO + {4'd0, i_head.num_bcd[4*dig_idx +: 4]};

        load       = !r_out_valid || i_pop;
        o_head_pop = load && !i_head_empty && is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_step      <= '0;
        end else if (load) begin
            r_out_valid <= !i_head_empty;
            if (!i_head_empty) begin
                r_busy <= !is_last;
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_head_empty) begin
            r_out_byte <= byte_sel;
            r_out_last <= is_last;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule
